### hdl/assert_macros.svh
// Assertion macros shared by the ordered list engine RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define OLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ole_pkg.sv
// Shared types and constants for the ordered list engine.
// No dependencies; used by ole_cell and ordered_list_engine.
package ole_pkg;

  // Fixed field widths
  localparam int VAL_W     = 32;
  localparam int POS_W     = 6;
  localparam int OUT_LEN_W = 6;
  // Wide enough for any length up to the largest supported capacity (64)
  localparam int LEN_W     = 7;
  localparam int IDX_W     = 6;

  // Request codes
  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_DELETE     = 2'd2,
    REQ_READ_ALL   = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_BADIDX = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CO_HOLD       = 3'd0,
    CO_PUSH_FRONT = 3'd1,
    CO_PUSH_BACK  = 3'd2,
    CO_DELETE     = 3'd3,
    CO_ROTATE     = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [LEN_W-1:0]   len;  // length before this cycle's operation
    logic [POS_W-1:0]   pos;  // delete position
  } cell_cmd_t;

endpackage

### hdl/ole_cell.sv
// One storage cell of the list chain: holds one entry and trades it with its neighbors.
// Depends on ole_pkg.
module ole_cell
  import ole_pkg::*;
(
  input  logic                    clk,
  input  cell_cmd_t               cmd,
  input  logic        [IDX_W-1:0] my_idx,
  input  logic signed [VAL_W-1:0] left_val,   // entry of cell my_idx-1
  input  logic signed [VAL_W-1:0] right_val,  // entry of cell my_idx+1
  input  logic signed [VAL_W-1:0] head_val,   // entry of cell 0
  input  logic signed [VAL_W-1:0] new_val,
  output logic signed [VAL_W-1:0] val_r
);

  logic signed [VAL_W-1:0] val_nxt;
  logic        [LEN_W-1:0] idx_ext;
  logic        [LEN_W-1:0] pos_ext;
  logic        [LEN_W-1:0] idx_plus1;

  assign idx_ext   = LEN_W'(my_idx);
  assign pos_ext   = LEN_W'(cmd.pos);
  assign idx_plus1 = idx_ext + LEN_W'(1);

  // Next entry by operation
  always_comb begin
    val_nxt = val_r;
    unique case (cmd.op)
      CO_HOLD: begin
        val_nxt = val_r;
      end
      CO_PUSH_FRONT: begin
        val_nxt = (my_idx == '0) ? new_val : left_val;
      end
      CO_PUSH_BACK: begin
        if (idx_ext == cmd.len) val_nxt = new_val;
      end
      CO_DELETE: begin
        if (idx_ext >= pos_ext) val_nxt = right_val;
      end
      CO_ROTATE: begin
        // tail of the live list wraps around to the head
        val_nxt = (idx_plus1 == cmd.len) ? head_val : right_val;
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### hdl/ordered_list_engine.sv
// Ordered list engine top level: request decode, length tracking, result register.
// Depends on ole_pkg, ole_cell and assert_macros.svh.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit entries in a chain of
// cells, entry 0 at the front. Requests come in on the in_ channel (valid/ready)
// and results leave on the out_ channel (valid/ready) from an output register.
// Insert front, insert back and delete shift the chain in the cycle the request
// beat is taken; their single result beat is valid the next cycle.
// Read-all rotates the chain by one cell per result beat and shows cell 0, so a
// list of N entries returns N beats, one per cycle while out_ready is high, the
// first registered from the read state entered on the request beat; after N rotations
// the order is as before. An empty read gives one beat with status empty.
// Throughput: one request per cycle for insert and delete when the receiver keeps
// out_ready high; read-all holds off new requests until its rotation of the chain
// is done. A new request is taken only once the previous one has handed all of its
// beats to the output register.
// Reset (synchronous, rst_n low) empties the list; entry contents are not cleared.
// When the receiver stalls, the result beat holds in the output register and the
// readout rotation pauses, so no beat is lost or repeated.
`include "assert_macros.svh"

module ordered_list_engine
  import ole_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_req_type,
  input  logic signed [VAL_W-1:0]     in_item_value,
  input  logic [POS_W-1:0]            in_position,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic signed [VAL_W-1:0]     out_read_value,
  output logic [OUT_LEN_W-1:0]        out_length,
  output logic                        out_last_of_run
);

  localparam int LW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  logic [LW-1:0]           len_r, len_nxt;
  logic [LW-1:0]           cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [OUT_LEN_W-1:0]    out_len_r, out_len_nxt;
  logic                    out_last_r, out_last_nxt;

  cell_cmd_t               cmd;
  logic                    out_free;
  logic                    in_fire;
  logic                    list_full;
  logic                    read_last;
  logic [LEN_W-1:0]        len_ext;
  logic [LEN_W-1:0]        len_nxt_ext;
  logic signed [VAL_W-1:0] cell_val [CAPACITY];

  assign out_free    = !out_valid_r || out_ready;
  assign in_ready    = (state_r == S_IDLE) && out_free;
  assign in_fire     = in_valid && in_ready;
  assign list_full   = (len_r == LW'(CAPACITY));
  assign len_ext     = LEN_W'(len_r);
  assign len_nxt_ext = LEN_W'(len_nxt);
  assign read_last   = (LW'(cnt_r + LW'(1)) == len_r);

  // Request decode, readout sequencing and result register load
  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;
    cmd.op         = CO_HOLD;
    cmd.len        = len_ext;
    cmd.pos        = in_position;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
          case (req_t'(in_req_type))
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              if (list_full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                cmd.op = (req_t'(in_req_type) == REQ_PUSH_FRONT) ? CO_PUSH_FRONT
                                                                 : CO_PUSH_BACK;
                len_nxt        = len_r + LW'(1);
                out_status_nxt = STAT_OK;
              end
            end
            REQ_DELETE: begin
              if (len_r == '0) begin
                out_status_nxt = STAT_EMPTY;
              end else if (LEN_W'(in_position) >= len_ext) begin
                out_status_nxt = STAT_BADIDX;
              end else begin
                cmd.op         = CO_DELETE;
                len_nxt        = len_r - LW'(1);
                out_status_nxt = STAT_OK;
              end
            end
            default: begin
              // read-all
              if (len_r == '0) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
                cnt_nxt       = '0;
              end
            end
          endcase
          out_len_nxt = len_nxt_ext[OUT_LEN_W-1:0];
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd.op         = CO_ROTATE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_value_nxt  = cell_val[0];
          out_len_nxt    = len_ext[OUT_LEN_W-1:0];
          out_last_nxt   = read_last;
          cnt_nxt        = cnt_r + LW'(1);
          if (read_last) state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Chain of entry cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    ole_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .my_idx    (IDX_W'(i)),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (cell_val[0]),
      .new_val   (in_item_value),
      .val_r     (cell_val[i])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_value_r;
  assign out_length      = out_len_r;
  assign out_last_of_run = out_last_r;

  // Checks
  `OLE_ASSERT_NOW(a_len_bound, 1'b1, len_r <= LW'(CAPACITY), "list length above capacity")
  `OLE_ASSERT_NOW(a_cnt_bound, state_r == S_READ, cnt_r < len_r, "readout count past length")
  `OLE_ASSERT_NEXT(a_push_grow,
    in_fire && !list_full && (in_req_type == REQ_PUSH_FRONT || in_req_type == REQ_PUSH_BACK),
    len_r == LW'($past(len_r) + LW'(1)), "insert did not grow the list")
  `OLE_ASSERT_NOW(a_midrun_read, out_valid_r && !out_last_r, state_r == S_READ,
    "non-final beat outside readout")

endmodule
